// ===== rtl/uart_rx_ring_with_busy_frame_detect_top_macros.svh =====
// Assertion macros shared by the receive ring modules.
`ifndef UART_RX_RING_WITH_BUSY_FRAME_DETECT_TOP_MACROS_SVH
`define UART_RX_RING_WITH_BUSY_FRAME_DETECT_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define URRBFD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define URRBFD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/urrbfd_pkg.sv =====
// Package: sizes, frame constants and inter-module types of the receive ring.
`default_nettype none

package urrbfd_pkg;

	localparam int RING_DEPTH   = 256;
	localparam int RING_AW      = $clog2(RING_DEPTH);
	localparam int CAPTURE_WRAP = 64;
	localparam int CAP_CW       = $clog2(CAPTURE_WRAP);
	localparam int BYTE_W       = 8;
	localparam int ADDR_W       = 7;
	localparam int LIMIT_W      = 7;
	localparam int MAX_POP      = 64;
	localparam int MIN_FRAME    = 10;

	localparam logic [BYTE_W-1:0] FRAME_FLAG = 8'h7e;
	localparam logic [BYTE_W-1:0] RNR_LENGTH = 8'd9;

	// Received byte offered to the frame capture
	typedef struct packed {
		logic              step;
		logic [BYTE_W-1:0] data;
	} cap_req_t;

	// Frame capture verdict for the offered byte
	typedef struct packed {
		logic hit;
	} cap_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/urrbfd_if.sv =====
// Handshake interfaces for the input and result channels.
`default_nettype none

interface urrbfd_in_if;
	logic                              valid;
	logic                              ready;
	logic                              kind;
	logic [urrbfd_pkg::BYTE_W-1:0]     rx_byte;
	logic                              busy_req;
	logic [urrbfd_pkg::LIMIT_W-1:0]    read_limit;

	modport source (output valid, kind, rx_byte, busy_req, read_limit, input ready);
	modport sink   (input valid, kind, rx_byte, busy_req, read_limit, output ready);
endinterface

interface urrbfd_out_if;
	logic                              valid;
	logic                              ready;
	logic [urrbfd_pkg::BYTE_W-1:0]     data_byte;
	logic                              data_valid;
	logic                              last;
	logic                              send_not_ready;

	modport source (output valid, data_byte, data_valid, last, send_not_ready, input ready);
	modport sink   (input valid, data_byte, data_valid, last, send_not_ready, output ready);
endinterface

`default_nettype wire

// ===== rtl/uart_rx_ring_with_busy_frame_detect_top.sv =====
// Top level of the UART receive ring with busy-time frame detection.
// A received byte (kind 0) is written to a 256-entry ring and, while busy_req
// is set, fed to a frame capture; its single result is registered in the RX
// state once the output register is free, and the input is ready again as
// that result is presented. A read request (kind 1) pops bytes in order,
// one result per byte, stopping after read_limit bytes (clamped to 1 through
// 64), after a 0x7e byte or when the ring empties; an empty ring gives one
// invalid result. Every pop goes through the single registered read port of
// the ring RAM before the sequencer emits it. Results wait in an output
// register, so a stalled result channel only pauses the sequencer.
// Writing meter_address is allowed only while the block is idle.
`default_nettype none

module uart_rx_ring_with_busy_frame_detect_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	urrbfd_in_if.sink                          in_ch,
	urrbfd_out_if.source                       out_ch,
	input  wire logic                          cfg_we,
	input  wire logic [urrbfd_pkg::ADDR_W-1:0] cfg_wdata
);

	urrbfd_pkg::cap_req_t           cap_req;
	urrbfd_pkg::cap_rsp_t           cap_rsp;
	logic                           ram_we;
	logic [urrbfd_pkg::RING_AW-1:0] ram_waddr;
	logic [urrbfd_pkg::BYTE_W-1:0]  ram_wdata;
	logic [urrbfd_pkg::RING_AW-1:0] ram_raddr;
	logic [urrbfd_pkg::BYTE_W-1:0]  ram_rdata;

	// Ring store
	urrbfd_ram #(
		.Width (urrbfd_pkg::BYTE_W),
		.Depth (urrbfd_pkg::RING_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Frame capture and station address
	urrbfd_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.cap_req   (cap_req),
		.cap_rsp   (cap_rsp)
	);

	// Sequencer and result register
	urrbfd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cap_req   (cap_req),
		.cap_rsp   (cap_rsp),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

endmodule

`default_nettype wire

// ===== rtl/urrbfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module urrbfd_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem_q [Depth];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/urrbfd_frame.sv =====
// Frame capture and not-ready detection for bytes received while busy.
`default_nettype none
`include "uart_rx_ring_with_busy_frame_detect_top_macros.svh"

module urrbfd_frame (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [urrbfd_pkg::ADDR_W-1:0]     cfg_wdata,
	input  wire urrbfd_pkg::cap_req_t              cap_req,
	output urrbfd_pkg::cap_rsp_t                   cap_rsp
);

	logic [urrbfd_pkg::ADDR_W-1:0] meter_address_q;
	logic [urrbfd_pkg::BYTE_W-1:0] cap_q [4];
	logic [urrbfd_pkg::CAP_CW-1:0] cnt_q;
	logic [urrbfd_pkg::CAP_CW-1:0] cnt_base;
	logic [urrbfd_pkg::CAP_CW-1:0] cnt_next;
	logic                          hit;

	// Restart the count unless a frame flag opened the capture.
	// A hit needs the base count at nine or more, so bytes two and three
	// are not rewritten by this byte and the stored values can be used.
	always_comb begin
		cnt_base = (cap_q[0] != urrbfd_pkg::FRAME_FLAG) ? '0 : cnt_q;
		cnt_next = cnt_base + 1'b1;
		hit = cap_req.step
			&& (cnt_next >= urrbfd_pkg::CAP_CW'(urrbfd_pkg::MIN_FRAME))
			&& (cap_q[2] == urrbfd_pkg::RNR_LENGTH)
			&& (cap_q[3][urrbfd_pkg::BYTE_W-1:1] == meter_address_q);
		cap_rsp.hit = hit;
	end

	// Station address register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			meter_address_q <= '0;
		end else if (cfg_we) begin
			meter_address_q <= cfg_wdata;
		end
	end

	// Capture the head of the frame and advance the count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < 4; i++) begin
				cap_q[i] <= '0;
			end
		end else if (cap_req.step) begin
			for (int i = 0; i < 4; i++) begin
				if (cnt_base == urrbfd_pkg::CAP_CW'(i)) begin
					cap_q[i] <= cap_req.data;
				end
			end
			cnt_q <= hit ? '0 : cnt_next;
		end
	end

	`URRBFD_ASSERT_NEXT(a_hit_clears_count, hit, cnt_q == '0, "count not cleared after frame hit")

endmodule

`default_nettype wire

// ===== rtl/urrbfd_seq.sv =====
// Sequencer: ring indexes, pop loop over the RAM read port, result register.
`default_nettype none
`include "uart_rx_ring_with_busy_frame_detect_top_macros.svh"

module urrbfd_seq (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	urrbfd_in_if.sink                               in_ch,
	urrbfd_out_if.source                            out_ch,
	output urrbfd_pkg::cap_req_t                    cap_req,
	input  wire urrbfd_pkg::cap_rsp_t               cap_rsp,
	output logic                                    ram_we,
	output logic [urrbfd_pkg::RING_AW-1:0]          ram_waddr,
	output logic [urrbfd_pkg::BYTE_W-1:0]           ram_wdata,
	output logic [urrbfd_pkg::RING_AW-1:0]          ram_raddr,
	input  wire logic [urrbfd_pkg::BYTE_W-1:0]      ram_rdata
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_RX    = 4'b0010,
		S_FETCH = 4'b0100,
		S_EMIT  = 4'b1000
	} state_t;

	state_t                         state_q;
	logic [urrbfd_pkg::RING_AW-1:0] wr_q;
	logic [urrbfd_pkg::RING_AW-1:0] rd_q;
	logic [urrbfd_pkg::RING_AW-1:0] wr_next;
	logic [urrbfd_pkg::RING_AW-1:0] rd_next;
	logic [urrbfd_pkg::LIMIT_W-1:0] limit_q;
	logic [urrbfd_pkg::LIMIT_W-1:0] limit_sat;
	logic [urrbfd_pkg::LIMIT_W-1:0] n_q;
	logic [urrbfd_pkg::LIMIT_W-1:0] n_next;
	logic                           nr_q;
	logic                           out_valid_q;
	logic [urrbfd_pkg::BYTE_W-1:0]  out_byte_q;
	logic                           out_dv_q;
	logic                           out_last_q;
	logic                           out_nr_q;
	logic                           acc;
	logic                           slot_free;
	logic                           out_load;
	logic                           ring_empty;
	logic                           pop_last;

	// Handshake and index arithmetic
	always_comb begin
		in_ch.ready = (state_q == S_IDLE);
		acc         = in_ch.valid && in_ch.ready;
		slot_free   = !out_valid_q || out_ch.ready;
		out_load    = slot_free && ((state_q == S_RX) || (state_q == S_EMIT));
		wr_next     = wr_q + 1'b1;
		rd_next     = rd_q + 1'b1;
		n_next      = n_q + 1'b1;
		ring_empty  = (rd_q == wr_q);
		pop_last    = (n_next >= limit_q) || (ram_rdata == urrbfd_pkg::FRAME_FLAG)
			|| (rd_next == wr_q);
	end

	// Clamp the read limit to one through the pop maximum
	always_comb begin
		priority if (in_ch.read_limit == '0) begin
			limit_sat = urrbfd_pkg::LIMIT_W'(1);
		end else if (in_ch.read_limit > urrbfd_pkg::LIMIT_W'(urrbfd_pkg::MAX_POP)) begin
			limit_sat = urrbfd_pkg::LIMIT_W'(urrbfd_pkg::MAX_POP);
		end else begin
			limit_sat = in_ch.read_limit;
		end
	end

	// Ring RAM and frame capture hookup
	always_comb begin
		ram_we       = acc && !in_ch.kind;
		ram_waddr    = wr_q;
		ram_wdata    = in_ch.rx_byte;
		ram_raddr    = rd_q;
		cap_req.step = acc && !in_ch.kind && in_ch.busy_req;
		cap_req.data = in_ch.rx_byte;
	end

	// Result channel
	always_comb begin
		out_ch.valid          = out_valid_q;
		out_ch.data_byte      = out_byte_q;
		out_ch.data_valid     = out_dv_q;
		out_ch.last           = out_last_q;
		out_ch.send_not_ready = out_nr_q;
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			wr_q        <= '0;
			rd_q        <= '0;
			n_q         <= '0;
			limit_q     <= urrbfd_pkg::LIMIT_W'(1);
			nr_q        <= 1'b0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_dv_q    <= 1'b0;
			out_last_q  <= 1'b0;
			out_nr_q    <= 1'b0;
		end else begin
			// Drop a result once it is taken, unless a new one replaces it
			if (out_valid_q && out_ch.ready && !out_load) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (!in_ch.kind) begin
							wr_q    <= wr_next;
							nr_q    <= cap_rsp.hit;
							if (cap_rsp.hit) begin
								rd_q <= wr_next;
							end
							state_q <= S_RX;
						end else begin
							limit_q <= limit_sat;
							n_q     <= '0;
							nr_q    <= 1'b0;
							state_q <= ring_empty ? S_RX : S_FETCH;
						end
					end
				end
				S_RX: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= '0;
						out_dv_q    <= 1'b0;
						out_last_q  <= 1'b1;
						out_nr_q    <= nr_q;
						state_q     <= S_IDLE;
					end
				end
				S_FETCH: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (slot_free) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= ram_rdata;
						out_dv_q    <= 1'b1;
						out_last_q  <= pop_last;
						out_nr_q    <= 1'b0;
						rd_q        <= rd_next;
						n_q         <= n_next;
						state_q     <= pop_last ? S_IDLE : S_FETCH;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`URRBFD_ASSERT_NOW(a_invalid_is_final, out_valid_q && !out_dv_q,
		(out_byte_q == '0) && out_last_q, "invalid result must be zero and final")
	`URRBFD_ASSERT_NOW(a_nr_not_on_pop, out_valid_q && out_nr_q, !out_dv_q,
		"not-ready flag on a popped byte")
	`URRBFD_ASSERT_NEXT(a_hit_discards, cap_rsp.hit, rd_q == wr_q,
		"frame hit did not discard unread data")
	`URRBFD_ASSERT_NOW(a_pop_within_limit, state_q == S_EMIT, n_q < limit_q,
		"pop count reached the limit")

endmodule

`default_nettype wire

// ===== tb/uart_rx_ring_with_busy_frame_detect_top_test.sv =====
// Self-checking testbench for the UART receive ring with busy-time frame detection.
`timescale 1ns / 100ps

module uart_rx_ring_with_busy_frame_detect_top_test;
	import urrbfd_pkg::*;

	localparam int CLK_HALF    = 2;
	localparam int RESET_CYC   = 2;
	localparam int SETTLE      = 4;
	localparam int TAIL        = 40;
	localparam int WATCHDOG    = 1000;
	localparam int PHASES      = 5;
	localparam int PHASE_ITEMS = 24;
	localparam int BURST_LEN   = 264;
	localparam int PRINT_CAP   = 30;

	localparam logic KIND_RX   = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [1:0] {ACT_ITEM, ACT_DRAIN, ACT_CFG} act_t;

	typedef enum int {
		FAULT_NONE,
		FAULT_FLAG,
		FAULT_LENGTH,
		FAULT_ADDR,
		FAULT_IDLE_BYTE,
		FAULT_SHORT
	} frame_fault_t;

	typedef struct {
		act_t               act;
		logic               kind;
		logic [BYTE_W-1:0]  rx_byte;
		logic               busy_req;
		logic [LIMIT_W-1:0] read_limit;
		logic [ADDR_W-1:0]  addr;
		int                 gap;
	} line_event_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              data_valid;
		logic              last;
		logic              send_not_ready;
	} ring_out_t;

	typedef struct packed {
		logic [3:0][BYTE_W-1:0] bytes;
		logic [CAP_CW-1:0]      cnt;
	} capture_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [ADDR_W-1:0]   cfg_wdata;

	urrbfd_in_if  in_ch ();
	urrbfd_out_if out_ch ();

	uart_rx_ring_with_busy_frame_detect_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #(CLK_HALF) clk = ~clk;

	// Stimulus waiting to go out and ring results still owed by the block
	line_event_t line_events [$];
	ring_out_t   ring_out_q [$];

	// Ring model state, advanced at each accepted item
	logic [BYTE_W-1:0]  ring_mem [RING_DEPTH];
	logic [RING_AW-1:0] wr_ptr = '0;
	logic [RING_AW-1:0] rd_ptr = '0;
	capture_t           cap_now = '0;
	logic [ADDR_W-1:0]  own_addr = '0;

	// Generator-side view of the capture, used to line frames up
	capture_t           shadow = '0;
	logic [ADDR_W-1:0]  gen_addr = '0;
	bit                 gen_calm = 1'b0;

	int  issued_cnt   = 0;
	int  accepted_cnt = 0;
	int  rx_seen      = 0;
	int  reads_seen   = 0;
	int  popped_cnt   = 0;
	int  nr_frames    = 0;
	int  cfg_writes   = 0;
	int  result_cnt   = 0;
	int  err_cnt      = 0;
	int  quiet_cycles = 0;
	int  gap_cnt      = 0;
	int  settle_cnt   = 0;
	int  stall_left   = 0;
	int  calm_left    = 0;
	bit  in_fire      = 1'b0;

	// Advance the capture by one busy byte; flag a matching not-ready frame
	function automatic capture_t capture_next(capture_t c, logic [BYTE_W-1:0] b,
			logic [ADDR_W-1:0] addr, output logic hit);
		capture_t n;
		n = c;
		hit = 1'b0;
		if (n.bytes[0] != FRAME_FLAG) n.cnt = '0;
		if (n.cnt < 4) n.bytes[n.cnt[1:0]] = b;
		n.cnt = n.cnt + 1'b1;
		if (n.cnt >= MIN_FRAME && n.bytes[2] == RNR_LENGTH && (n.bytes[3] >> 1) == addr) begin
			hit = 1'b1;
			n.cnt = '0;
		end
		return n;
	endfunction

	// Work out the results of one accepted item and queue them
	task automatic ring_advance(input logic kind, input logic [BYTE_W-1:0] b,
			input logic busy, input logic [LIMIT_W-1:0] limit);
		ring_out_t r;
		logic hit;
		int lim;
		int n;
		logic [BYTE_W-1:0] v;
		logic stop;
		r = '0;
		hit = 1'b0;
		if (kind == KIND_RX) begin
			rx_seen++;
			ring_mem[wr_ptr] = b;
			wr_ptr = wr_ptr + 1'b1;
			if (busy) cap_now = capture_next(cap_now, b, own_addr, hit);
			if (hit) begin
				rd_ptr = wr_ptr;
				nr_frames++;
			end
			r.last = 1'b1;
			r.send_not_ready = hit;
			ring_out_q.push_back(r);
		end else begin
			reads_seen++;
			lim = int'(limit);
			if (lim == 0) lim = 1;
			if (lim > MAX_POP) lim = MAX_POP;
			if (rd_ptr == wr_ptr) begin
				r.last = 1'b1;
				ring_out_q.push_back(r);
			end else begin
				n = 0;
				stop = 1'b0;
				while (!stop) begin
					v = ring_mem[rd_ptr];
					rd_ptr = rd_ptr + 1'b1;
					n++;
					stop = (n >= lim) || (v == FRAME_FLAG) || (rd_ptr == wr_ptr);
					r.data_byte = v;
					r.data_valid = 1'b1;
					r.last = stop;
					ring_out_q.push_back(r);
					popped_cnt++;
				end
			end
		end
	endtask

	task automatic flag_mismatch(input string what, input logic [BYTE_W-1:0] want,
			input logic [BYTE_W-1:0] got);
		if (err_cnt < PRINT_CAP)
			$display("%0t ns result %0d: %s expected %0h got %0h", $time, result_cnt, what,
				want, got);
		err_cnt++;
	endtask

	// Mostly short gaps, a few long; none in calm stretches
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (gen_calm || r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [LIMIT_W-1:0] draw_limit();
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) return '0;
		if (r < 8) return LIMIT_W'($urandom_range(MAX_POP + 1, 127));
		if (r < 30) return LIMIT_W'(1);
		return LIMIT_W'($urandom_range(1, MAX_POP));
	endfunction

	// Line bytes carry the delimiter often enough to stop reads
	function automatic logic [BYTE_W-1:0] line_byte();
		if ($urandom_range(0, 5) == 0) return FRAME_FLAG;
		return BYTE_W'($urandom_range(0, 255));
	endfunction

	task automatic queue_rx(input logic [BYTE_W-1:0] b, input logic busy);
		line_event_t s;
		logic hit;
		s.act = ACT_ITEM;
		s.kind = KIND_RX;
		s.rx_byte = b;
		s.busy_req = busy;
		s.read_limit = LIMIT_W'($urandom_range(0, 127));
		s.addr = '0;
		s.gap = draw_gap();
		line_events.push_back(s);
		issued_cnt++;
		if (busy) shadow = capture_next(shadow, b, gen_addr, hit);
	endtask

	task automatic queue_read(input logic [LIMIT_W-1:0] limit);
		line_event_t s;
		s.act = ACT_ITEM;
		s.kind = KIND_READ;
		s.rx_byte = BYTE_W'($urandom_range(0, 255));
		s.busy_req = 1'($urandom_range(0, 1));
		s.read_limit = limit;
		s.addr = '0;
		s.gap = draw_gap();
		line_events.push_back(s);
		issued_cnt++;
	endtask

	task automatic queue_ctrl(input act_t act, input logic [ADDR_W-1:0] addr);
		line_event_t s;
		s = '{act: act, kind: KIND_RX, rx_byte: '0, busy_req: 1'b0, read_limit: '0,
			addr: addr, gap: 0};
		line_events.push_back(s);
		if (act == ACT_CFG) gen_addr = addr;
	endtask

	// Queue one busy frame, optionally broken, with reads mixed in
	task automatic queue_frame(input frame_fault_t fault);
		logic [BYTE_W-1:0] hdr [4];
		int len;
		int idle_pos;
		// flush a stuck capture so the frame starts at position zero
		while (shadow.bytes[0] == FRAME_FLAG && shadow.cnt != 0) queue_rx(line_byte(), 1'b1);
		hdr[0] = FRAME_FLAG;
		hdr[1] = line_byte();
		hdr[2] = RNR_LENGTH;
		hdr[3] = {gen_addr, 1'($urandom_range(0, 1))};
		len = MIN_FRAME;
		idle_pos = -1;
		case (fault)
			FAULT_FLAG: begin
				hdr[0] = BYTE_W'($urandom_range(0, 255));
				if (hdr[0] == FRAME_FLAG) hdr[0] = 8'h7f;
			end
			FAULT_LENGTH: hdr[2] = RNR_LENGTH + BYTE_W'($urandom_range(1, 255));
			FAULT_ADDR: hdr[3] = {gen_addr + 7'd1 + ADDR_W'($urandom_range(0, 125)), hdr[3][0]};
			FAULT_IDLE_BYTE: idle_pos = $urandom_range(0, MIN_FRAME - 1);
			FAULT_SHORT: len = $urandom_range(3, MIN_FRAME - 1);
			default: ;
		endcase
		for (int i = 0; i < len; i++) begin
			if (i > 0 && $urandom_range(0, 99) < 12) queue_read(draw_limit());
			queue_rx(i < 4 ? hdr[i] : line_byte(), i != idle_pos);
		end
	endtask

	// Drive the input channel and the register port
	always @(negedge clk) begin
		logic cfg_go;
		cfg_go = 1'b0;
		if (arst_n) begin
			if (in_ch.valid && !in_fire) begin
				// hold the item until it is taken
			end else if (line_events.size() == 0) begin
				in_ch.valid <= 1'b0;
			end else if (line_events[0].act == ACT_ITEM) begin
				if (gap_cnt < line_events[0].gap) begin
					in_ch.valid <= 1'b0;
					gap_cnt++;
				end else begin
					in_ch.valid <= 1'b1;
					in_ch.kind <= line_events[0].kind;
					in_ch.rx_byte <= line_events[0].rx_byte;
					in_ch.busy_req <= line_events[0].busy_req;
					in_ch.read_limit <= line_events[0].read_limit;
					void'(line_events.pop_front());
					gap_cnt = 0;
				end
			end else begin
				// hold off until every owed result is back; settle first before an address write
				in_ch.valid <= 1'b0;
				if (ring_out_q.size() != 0) begin
					settle_cnt = 0;
				end else if (line_events[0].act == ACT_DRAIN) begin
					void'(line_events.pop_front());
				end else if (settle_cnt < SETTLE) begin
					settle_cnt++;
				end else begin
					cfg_go = 1'b1;
					cfg_wdata <= line_events[0].addr;
					own_addr = line_events[0].addr;
					cfg_writes++;
					settle_cnt = 0;
					void'(line_events.pop_front());
				end
			end
			cfg_we <= cfg_go;
		end
	end

	// Stall the result channel at random, with calm stretches
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				out_ch.ready <= 1'b0;
				stall_left--;
			end else if (calm_left > 0) begin
				out_ch.ready <= 1'b1;
				calm_left--;
			end else begin
				if ($urandom_range(0, 99) < 4) calm_left = $urandom_range(40, 160);
				else if ($urandom_range(0, 99) < 30) stall_left = $urandom_range(0, 9) == 0 ?
					$urandom_range(8, 40) : $urandom_range(1, 3);
				out_ch.ready <= (stall_left == 0);
			end
		end
	end

	// Sample both channels, predict and compare
	always @(posedge clk) begin
		ring_out_t want;
		in_fire <= in_ch.valid && in_ch.ready;
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				ring_advance(in_ch.kind, in_ch.rx_byte, in_ch.busy_req, in_ch.read_limit);
				accepted_cnt++;
			end
			if (out_ch.valid && out_ch.ready) begin
				if (ring_out_q.size() == 0) begin
					flag_mismatch("unexpected result, data_byte", '0, out_ch.data_byte);
				end else begin
					want = ring_out_q.pop_front();
					if (out_ch.data_byte !== want.data_byte)
						flag_mismatch("data_byte", want.data_byte, out_ch.data_byte);
					if (out_ch.data_valid !== want.data_valid)
						flag_mismatch("data_valid", BYTE_W'(want.data_valid),
							BYTE_W'(out_ch.data_valid));
					if (out_ch.last !== want.last)
						flag_mismatch("last", BYTE_W'(want.last), BYTE_W'(out_ch.last));
					if (out_ch.send_not_ready !== want.send_not_ready)
						flag_mismatch("send_not_ready", BYTE_W'(want.send_not_ready),
							BYTE_W'(out_ch.send_not_ready));
				end
				result_cnt++;
			end
			// end the run if the block goes quiet
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG) begin
				$display("watchdog: no handshake for %0d cycles, %0d results owed", WATCHDOG,
					ring_out_q.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		int start;
		int pick;
		logic [BYTE_W-1:0] b;
		logic [ADDR_W-1:0] addr;

		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_ch.valid = 1'b0;
		in_ch.kind = KIND_RX;
		in_ch.rx_byte = '0;
		in_ch.busy_req = 1'b0;
		in_ch.read_limit = '0;
		out_ch.ready = 1'b0;

		// Directed: empty read, limit edges, delimiter stop, a matching frame at reset address
		queue_read(LIMIT_W'(1));
		queue_rx(8'h00, 1'b0);
		queue_rx(8'hff, 1'b0);
		queue_rx(FRAME_FLAG, 1'b0);
		queue_rx(8'h55, 1'b0);
		queue_read(LIMIT_W'(0));
		queue_read(LIMIT_W'(127));
		queue_read(LIMIT_W'(64));
		queue_rx(FRAME_FLAG, 1'b0);
		queue_rx(8'h80, 1'b0);
		queue_read(LIMIT_W'(1));
		queue_rx(FRAME_FLAG, 1'b1);
		queue_rx(8'h01, 1'b1);
		queue_rx(RNR_LENGTH, 1'b1);
		queue_rx(8'h01, 1'b1);
		queue_rx(8'haa, 1'b1);
		queue_rx(FRAME_FLAG, 1'b1);
		queue_rx(8'h00, 1'b1);
		queue_rx(8'hff, 1'b1);
		queue_rx(8'h12, 1'b1);
		queue_rx(8'h34, 1'b1);
		queue_read(LIMIT_W'(64));

		// Random phases, each under its own station address
		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: addr = 7'd127;
				1: addr = 7'd0;
				4: addr = 7'd1;
				default: addr = ADDR_W'($urandom_range(0, 127));
			endcase
			queue_ctrl(ACT_CFG, addr);
			start = issued_cnt;
			while (issued_cnt - start < PHASE_ITEMS) begin
				gen_calm = (p == 2) || ($urandom_range(0, 9) == 0);
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					queue_frame(FAULT_NONE);
				end else if (pick < 60) begin
					queue_frame(frame_fault_t'($urandom_range(FAULT_FLAG, FAULT_SHORT)));
				end else if (pick < 85) begin
					repeat ($urandom_range(1, 3)) queue_read(draw_limit());
				end else begin
					repeat ($urandom_range(1, 5)) queue_rx(line_byte(), 1'($urandom_range(0, 1)));
				end
				if (p == 3 && issued_cnt - start >= PHASE_ITEMS / 2 && line_events.size() > 0 &&
						line_events[$].act == ACT_ITEM && $urandom_range(0, 3) == 0)
					queue_ctrl(ACT_DRAIN, '0);
			end
			// lap the read index with idle bytes, then drain with saturating reads
			if (p == 1) begin
				queue_ctrl(ACT_DRAIN, '0);
				gen_calm = 1'b1;
				repeat (BURST_LEN) begin
					b = BYTE_W'($urandom_range(0, 255));
					if (b == FRAME_FLAG) b = 8'h00;
					queue_rx(b, 1'b0);
				end
				queue_read(LIMIT_W'(127));
				queue_read(LIMIT_W'(100));
				queue_read(LIMIT_W'(64));
				queue_read(LIMIT_W'(0));
				queue_read(LIMIT_W'(127));
			end
		end

		repeat (RESET_CYC) @(negedge clk);
		arst_n = 1'b1;

		while (line_events.size() != 0 || accepted_cnt != issued_cnt || ring_out_q.size() != 0)
			@(negedge clk);
		repeat (TAIL) @(negedge clk);

		$display("covered %0d items: %0d received bytes, %0d reads, %0d bytes popped",
			accepted_cnt, rx_seen, reads_seen, popped_cnt);
		$display("%0d not-ready frames, %0d address writes, %0d results, %0d mismatches",
			nr_frames, cfg_writes, result_cnt, err_cnt);
		if (err_cnt == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== uart_rx_ring_with_busy_frame_detect_top.f =====
+incdir+rtl
rtl/urrbfd_pkg.sv
rtl/urrbfd_if.sv
rtl/urrbfd_ram.sv
rtl/urrbfd_frame.sv
rtl/urrbfd_seq.sv
rtl/uart_rx_ring_with_busy_frame_detect_top.sv
tb/uart_rx_ring_with_busy_frame_detect_top_test.sv
